// File: rtl/fpx_pkg.sv
package fpx_pkg;

   // Command codes carried by a request.
   localparam logic [1:0] CMD_ENQUEUE      = 2'd0;
   localparam logic [1:0] CMD_DEQUEUE      = 2'd1;
   localparam logic [1:0] CMD_PRIO_DEQUEUE = 2'd2;

   // Status codes returned with every response.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_POP,
      ST_SCAN,
      ST_SHIFT_PRIME,
      ST_SHIFT,
      ST_DONE
   } fpx_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic idle;
      logic enq_write;
      logic set_full;
      logic set_empty;
      logic set_ok_zero;
      logic pop_take;
      logic scan_start;
      logic scan_step;
      logic shift_prime;
      logic shift_step;
      logic prio_take;
      logic publish;
   } fpx_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       req_valid;
      logic [1:0] command;
      logic       empty;
      logic       full;
      logic       scan_last;
      logic       shift_none;
      logic       shift_last;
      logic       out_free;
   } fpx_flags_type;

endpackage

// File: rtl/fpx_req_if.sv
interface fpx_req_if #(
   parameter int ID_BITS       = 16,
   parameter int PRIORITY_BITS = 8
) ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               command;
   logic [ID_BITS-1:0]       new_identifier;
   logic [PRIORITY_BITS-1:0] new_priority;

   modport source (output valid, command, new_identifier, new_priority, input ready);
   modport sink   (input valid, command, new_identifier, new_priority, output ready);
endinterface

// File: rtl/fpx_rsp_if.sv
interface fpx_rsp_if #(
   parameter int CAPACITY      = 16,
   parameter int ID_BITS       = 16,
   parameter int PRIORITY_BITS = 8
) ();
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic [ID_BITS-1:0]       removed_identifier;
   logic [PRIORITY_BITS-1:0] removed_priority;
   logic [CNT_W-1:0]         entry_count;

   modport source (output valid, status, removed_identifier, removed_priority, entry_count,
                   input ready);
   modport sink   (input valid, status, removed_identifier, removed_priority, entry_count,
                   output ready);
endinterface

// File: rtl/fifo_with_priority_extract.sv
// Channel   Direction  Handshake          Payload
// req_if    in         valid / ready      command, new_identifier, new_priority
// rsp_if    out        valid / ready      status, removed_identifier, removed_priority,
//                                         entry_count
//
// An enqueue, a plain dequeue, an empty or full rejection and an unused command
// each go from acceptance through DECODE (and POP for a plain dequeue) to DONE.
// A priority dequeue goes through DECODE, SCAN over the n held entries, SHIFT_PRIME
// and SHIFT over the n - 1 - p entries behind the winner at position p; the single
// read port of the entry memory paces scan and compaction, each reading one entry per cycle.
// Reset is synchronous and empties the queue; memory contents are not cleared.
// A response waiting in the output register does not block the next request, which
// is worked on and then held until the output register is free.
module fifo_with_priority_extract #(
   parameter int CAPACITY      = 16,
   parameter int ID_BITS       = 16,
   parameter int PRIORITY_BITS = 8
) (
   input logic       clock,
   input logic       reset,
   fpx_req_if.sink   req_if,
   fpx_rsp_if.source rsp_if
);
   import fpx_pkg::*;

   // The controller sequences each request through decode, scan and compaction;
   // the datapath owns the entry memory, the ring pointers and the response register.
   fpx_cmd_type   cmd;
   fpx_flags_type flags;

   fpx_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .cmd   (cmd)
   );

   fpx_dp #(
      .CAPACITY      (CAPACITY),
      .ID_BITS       (ID_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .cmd    (cmd),
      .flags  (flags)
   );

endmodule

// File: rtl/fpx_ctrl.sv
module fpx_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  fpx_pkg::fpx_flags_type flags,
   output fpx_pkg::fpx_cmd_type   cmd
);
   import fpx_pkg::*;

   fpx_state_type state_ff;
   fpx_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (flags.req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (flags.command)
               CMD_DEQUEUE:      state_in = flags.empty ? ST_DONE : ST_POP;
               CMD_PRIO_DEQUEUE: state_in = flags.empty ? ST_DONE : ST_SCAN;
               default:          state_in = ST_DONE;
            endcase
         end
         ST_POP:  state_in = ST_DONE;
         ST_SCAN: begin
            if (flags.scan_last) state_in = ST_SHIFT_PRIME;
         end
         ST_SHIFT_PRIME: state_in = flags.shift_none ? ST_DONE : ST_SHIFT;
         ST_SHIFT: begin
            if (flags.shift_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (flags.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: cmd.idle = 1'b1;
         ST_DECODE: begin
            case (flags.command)
               CMD_ENQUEUE: begin
                  if (flags.full) cmd.set_full = 1'b1;
                  else            cmd.enq_write = 1'b1;
               end
               CMD_DEQUEUE: begin
                  if (flags.empty) cmd.set_empty = 1'b1;
               end
               CMD_PRIO_DEQUEUE: begin
                  if (flags.empty) cmd.set_empty = 1'b1;
                  else             cmd.scan_start = 1'b1;
               end
               default: cmd.set_ok_zero = 1'b1;
            endcase
         end
         ST_POP:  cmd.pop_take = 1'b1;
         ST_SCAN: cmd.scan_step = 1'b1;
         ST_SHIFT_PRIME: begin
            if (flags.shift_none) cmd.prio_take = 1'b1;
            else                  cmd.shift_prime = 1'b1;
         end
         ST_SHIFT: begin
            cmd.shift_step = 1'b1;
            cmd.prio_take  = flags.shift_last;
         end
         ST_DONE: cmd.publish = flags.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

// File: rtl/fpx_dp.sv
module fpx_dp #(
   parameter int CAPACITY      = 16,
   parameter int ID_BITS       = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   fpx_req_if.sink                req_if,
   fpx_rsp_if.source              rsp_if,
   input  fpx_pkg::fpx_cmd_type   cmd,
   output fpx_pkg::fpx_flags_type flags
);
   import fpx_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int ENT_W = ID_BITS + PRIORITY_BITS;

   // Entry storage, a ring addressed from the oldest entry.
   logic [ENT_W-1:0] entry_mem_ff [CAPACITY];
   logic [ENT_W-1:0] rd_data_ff;

   logic [1:0]               op_ff, op_in;
   logic [ID_BITS-1:0]       new_id_ff, new_id_in;
   logic [PRIORITY_BITS-1:0] new_pri_ff, new_pri_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         scan_ff, scan_in;
   logic [IDX_W-1:0]         best_ff, best_in;
   logic [ID_BITS-1:0]       best_id_ff, best_id_in;
   logic [PRIORITY_BITS-1:0] best_pri_ff, best_pri_in;
   logic [1:0]               res_status_ff, res_status_in;
   logic [ID_BITS-1:0]       res_id_ff, res_id_in;
   logic [PRIORITY_BITS-1:0] res_pri_ff, res_pri_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_status_ff;
   logic [ID_BITS-1:0]       rsp_id_ff;
   logic [PRIORITY_BITS-1:0] rsp_pri_ff;
   logic [CNT_W-1:0]         rsp_count_ff;

   logic [ID_BITS-1:0]       rd_id;
   logic [PRIORITY_BITS-1:0] rd_pri;
   logic [CNT_W-1:0]         rd_pos;
   logic [IDX_W-1:0]         rd_addr;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [ENT_W-1:0]         wr_data;
   logic                     accept;

   // Map a position in arrival order onto a slot of the ring.
   function automatic logic [IDX_W-1:0] to_slot(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] pos);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(pos);
      if (sum >= (CNT_W+1)'(CAPACITY)) sum = sum - (CNT_W+1)'(CAPACITY);
      return sum[IDX_W-1:0];
   endfunction

   assign accept = req_if.valid & req_if.ready;
   assign rd_id  = rd_data_ff[ENT_W-1 -: ID_BITS];
   assign rd_pri = rd_data_ff[PRIORITY_BITS-1:0];

   always_comb begin
      if (cmd.scan_step)        rd_pos = CNT_W'(scan_ff + 1'b1);
      else if (cmd.shift_prime) rd_pos = CNT_W'(best_ff) + 1'b1;
      else if (cmd.shift_step)  rd_pos = CNT_W'(scan_ff + 2'd2);
      else                      rd_pos = '0;
      rd_addr = to_slot(head_ff, rd_pos);

      wr_en   = cmd.enq_write | cmd.shift_step;
      wr_addr = to_slot(head_ff, cmd.shift_step ? scan_ff : count_ff);
      wr_data = cmd.shift_step ? rd_data_ff : {new_id_ff, new_pri_ff};
   end

   always_ff @(posedge clock) begin
      if (wr_en) entry_mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   always_comb begin
      op_in         = op_ff;
      new_id_in     = new_id_ff;
      new_pri_in    = new_pri_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      best_in       = best_ff;
      best_id_in    = best_id_ff;
      best_pri_in   = best_pri_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_pri_in    = res_pri_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_if.ready;

      if (accept) begin
         op_in      = req_if.command;
         new_id_in  = req_if.new_identifier;
         new_pri_in = req_if.new_priority;
      end
      if (cmd.enq_write | cmd.set_full | cmd.set_empty | cmd.set_ok_zero) begin
         res_id_in  = '0;
         res_pri_in = '0;
         if (cmd.set_full)       res_status_in = STATUS_FULL;
         else if (cmd.set_empty) res_status_in = STATUS_EMPTY;
         else                    res_status_in = STATUS_OK;
      end
      if (cmd.enq_write) count_in = count_ff + 1'b1;
      if (cmd.pop_take) begin
         res_status_in = STATUS_OK;
         res_id_in     = rd_id;
         res_pri_in    = rd_pri;
         count_in      = count_ff - 1'b1;
         head_in       = (head_ff == IDX_W'(CAPACITY - 1)) ? '0 : head_ff + 1'b1;
      end
      if (cmd.scan_start) scan_in = '0;
      if (cmd.scan_step) begin
         // Strictly greater keeps the earliest entry among equal priorities.
         if (scan_ff == '0 || rd_pri > best_pri_ff) begin
            best_in     = scan_ff[IDX_W-1:0];
            best_id_in  = rd_id;
            best_pri_in = rd_pri;
         end
         scan_in = scan_ff + 1'b1;
      end
      if (cmd.shift_prime) scan_in = CNT_W'(best_ff);
      if (cmd.shift_step)  scan_in = scan_ff + 1'b1;
      if (cmd.prio_take) begin
         res_status_in = STATUS_OK;
         res_id_in     = best_id_ff;
         res_pri_in    = best_pri_ff;
         count_in      = count_ff - 1'b1;
      end
      if (cmd.publish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      new_id_ff     <= new_id_in;
      new_pri_ff    <= new_pri_in;
      scan_ff       <= scan_in;
      best_ff       <= best_in;
      best_id_ff    <= best_id_in;
      best_pri_ff   <= best_pri_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_pri_ff    <= res_pri_in;
      if (cmd.publish) begin
         rsp_status_ff <= res_status_ff;
         rsp_id_ff     <= res_id_ff;
         rsp_pri_ff    <= res_pri_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   always_comb begin
      flags.req_valid  = req_if.valid;
      flags.command    = op_ff;
      flags.empty      = (count_ff == '0);
      flags.full       = (count_ff == CNT_W'(CAPACITY));
      flags.scan_last  = ((CNT_W+1)'(scan_ff) + 1'b1) == (CNT_W+1)'(count_ff);
      flags.shift_none = ((CNT_W+1)'(best_ff) + 1'b1) >= (CNT_W+1)'(count_ff);
      flags.shift_last = ((CNT_W+1)'(scan_ff) + 2'd2) >= (CNT_W+1)'(count_ff);
      flags.out_free   = ~rsp_valid_ff | rsp_if.ready;
   end

   assign req_if.ready              = cmd.idle;
   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.status             = rsp_status_ff;
   assign rsp_if.removed_identifier = rsp_id_ff;
   assign rsp_if.removed_priority   = rsp_pri_ff;
   assign rsp_if.entry_count        = rsp_count_ff;

endmodule
